// ===== src/fisheye_coordinate_mapper_macros.svh =====
// Assertion macros shared by the fisheye coordinate mapper RTL.
// Depends on nothing; users must provide i_clk and i_rst_n in scope.
`ifndef FISHEYE_COORDINATE_MAPPER_MACROS_SVH
`define FISHEYE_COORDINATE_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcm assertion failed");

`endif

// ===== src/fcm_pkg.sv =====
// Package for the fisheye coordinate mapper: payload structs and fixed constants.
// Used by fisheye_coordinate_mapper; depends on nothing.
package fcm_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_W     = COORD_BITS + 1;
    localparam int HOFF_W     = COORD_BITS + 2;
    localparam int COLOR_W    = 24;
    localparam int DST_W      = 16;
    localparam int ADDR_W     = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    // Register select taken from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // The squared offset is scaled by 2^SQ_SHIFT before the first root, the
    // distance by 2^ROOT2_SHIFT before the second.
    localparam int SQ_SHIFT    = 18;
    localparam int ROOT2_SHIFT = 10;

    // Dividend 10 * 2^(F+10) seen above the F+4 quotient bits; all lower bits are zero.
    localparam int DIV_SEED = 640;

    localparam int DST_MAX = 32767;
    localparam int DST_MIN = -32768;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic [COLOR_W-1:0]    src_color;
    } t_src;

    typedef struct packed {
        logic signed [DST_W-1:0] dst_x;
        logic signed [DST_W-1:0] dst_y;
        logic                    in_bounds;
        logic [COLOR_W-1:0]      dst_color;
    } t_dst;

    typedef struct packed {
        logic signed [HOFF_W-1:0] hx;
        logic signed [HOFF_W-1:0] hy;
        logic                     zero;
        logic [COLOR_W-1:0]       color;
    } t_side;

endpackage

// ===== src/fisheye_coordinate_mapper.sv =====
// Fisheye coordinate mapper: radial r' = 10*sqrt(r) warp, one pixel per cycle unless stalled.
// Depends on fcm_pkg, fcm_isqrt_pipe and fisheye_coordinate_mapper_macros.svh.
//
// Usage:
//   Source channel: i_src_valid / i_src (x, y, color) / o_src_stall. A transaction
//   completes on a rising edge with i_src_valid high and o_src_stall low.
//   Result channel: o_dst_valid / o_dst (x, y, in_bounds, color) / i_dst_stall.
//   Every source transaction gives exactly one result, in order.
//   Configuration: APB-style port; image_width at address 0, image_height at 4.
//   Write them only while no transaction is in flight.
//   Throughput: one transaction per cycle while the output is not stalled. The
//   pipeline holds two bit-per-stage square roots and the bit-per-stage
//   restoring divider that forms the scale ratio.
//   A stalled result holds in the output register; while it is held the whole
//   pipeline freezes and o_src_stall rises. Bubbles still travel while the
//   output is free.
//   Reset empties the pipeline and loads width 640 and height 480.
`include "fisheye_coordinate_mapper_macros.svh"

module fisheye_coordinate_mapper #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_src_valid,
    input  fcm_pkg::t_src               i_src,
    output logic                        o_src_stall,
    output logic                        o_dst_valid,
    output fcm_pkg::t_dst               o_dst,
    input  logic                        i_dst_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int F      = RATIO_FRAC_BITS;
    localparam int MB     = fcm_pkg::SIZE_W;
    localparam int HW     = fcm_pkg::HOFF_W;
    localparam int SQW    = 2 * MB + 1;
    localparam int DW     = MB + 10;
    localparam int R1W    = 2 * DW;
    localparam int R2W    = ((DW + fcm_pkg::ROOT2_SHIFT + 1) / 2) * 2;
    localparam int SW     = R2W / 2;
    localparam int QB     = F + 4;
    localparam int PW     = HW + QB + 1;
    localparam int NW     = MB + F + 6;
    localparam int QW     = NW - F - 1;
    localparam int SIDE_W = $bits(fcm_pkg::t_side);
    localparam logic [NW-1:0] BIAS = (NW'(1) << (F + 1)) - NW'(1);

    // ---------------- configuration ----------------
    logic [fcm_pkg::SIZE_W-1:0] r_width;
    logic [fcm_pkg::SIZE_W-1:0] r_height;
    logic                       w_wr;

    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fcm_pkg::WIDTH_RESET;
            r_height <= fcm_pkg::HEIGHT_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                fcm_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[fcm_pkg::SIZE_W-1:0];
                fcm_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[fcm_pkg::SIZE_W-1:0];
                default:                   r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fcm_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-fcm_pkg::SIZE_W){1'b0}}, r_width};
            fcm_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-fcm_pkg::SIZE_W){1'b0}}, r_height};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic r_out_valid;
    logic w_adv;

    assign w_adv       = !(r_out_valid && i_dst_stall);
    assign o_src_stall = !w_adv;

    // ---------------- stage A: half-pixel offsets ----------------
    fcm_pkg::t_side n_a_side;
    fcm_pkg::t_side r_a_side;
    logic           r_a_valid;

    always_comb begin
        n_a_side.hx    = $signed({1'b0, i_src.src_x, 1'b0}) - $signed({1'b0, r_width});
        n_a_side.hy    = $signed({1'b0, i_src.src_y, 1'b0}) - $signed({1'b0, r_height});
        n_a_side.zero  = (n_a_side.hx == '0) && (n_a_side.hy == '0);
        n_a_side.color = i_src.src_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_src_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_side <= n_a_side;
        end
    end

    // ---------------- stage B: squares ----------------
    logic signed [2*HW-1:0] w_px;
    logic signed [2*HW-1:0] w_py;
    logic [2*MB-1:0]        r_b_sqx;
    logic [2*MB-1:0]        r_b_sqy;
    fcm_pkg::t_side         r_b_side;
    logic                   r_b_valid;

    assign w_px = r_a_side.hx * r_a_side.hx;
    assign w_py = r_a_side.hy * r_a_side.hy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_sqx  <= w_px[2*MB-1:0];
            r_b_sqy  <= w_py[2*MB-1:0];
            r_b_side <= r_a_side;
        end
    end

    // ---------------- stage C: sum of squares ----------------
    logic [SQW-1:0] r_c_sq;
    fcm_pkg::t_side r_c_side;
    logic           r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_sq   <= {1'b0, r_b_sqx} + {1'b0, r_b_sqy};
            r_c_side <= r_b_side;
        end
    end

    // ---------------- distance and its root ----------------
    logic [R1W-1:0]    w_rad1;
    logic              w_s1_valid;
    logic [DW-1:0]     w_d;
    logic [SIDE_W-1:0] w_s1_side;
    logic [R2W-1:0]    w_rad2;
    logic              w_s2_valid;
    logic [SW-1:0]     w_s;
    logic [SIDE_W-1:0] w_s2_side;

    assign w_rad1 = R1W'({r_c_sq, {fcm_pkg::SQ_SHIFT{1'b0}}});

    fcm_isqrt_pipe #(
        .IN_W   (R1W),
        .SIDE_W (SIDE_W)
    ) u_dist_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_c_valid),
        .i_rad   (w_rad1),
        .i_side  (r_c_side),
        .o_valid (w_s1_valid),
        .o_root  (w_d),
        .o_side  (w_s1_side)
    );

    assign w_rad2 = R2W'({w_d, {fcm_pkg::ROOT2_SHIFT{1'b0}}});

    fcm_isqrt_pipe #(
        .IN_W   (R2W),
        .SIDE_W (SIDE_W)
    ) u_root_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_s1_valid),
        .i_rad   (w_rad2),
        .i_side  (w_s1_side),
        .o_valid (w_s2_valid),
        .o_root  (w_s),
        .o_side  (w_s2_side)
    );

    // ---------------- ratio: 10 * 2^(F+10) / s, one quotient bit per stage ----------------
    logic           r_dv_valid [0:QB];
    logic [SW-1:0]  r_dv_rem   [0:QB];
    logic [QB-1:0]  r_dv_q     [0:QB];
    logic [SW-1:0]  r_dv_s     [0:QB];
    logic           r_dv_sat   [0:QB];
    fcm_pkg::t_side r_dv_side  [0:QB];
    logic [SW-1:0]  w_s_eff;

    assign w_s_eff = (w_s == '0) ? SW'(1) : w_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_valid[0] <= w_s2_valid;
        end
    end

    // A divisor no larger than the seed makes the quotient overflow the ratio format.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_rem[0]  <= SW'(fcm_pkg::DIV_SEED);
            r_dv_q[0]    <= '0;
            r_dv_s[0]    <= w_s_eff;
            r_dv_sat[0]  <= (w_s_eff <= SW'(fcm_pkg::DIV_SEED));
            r_dv_side[0] <= fcm_pkg::t_side'(w_s2_side);
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        logic [SW:0] w_rem2;
        logic [SW:0] w_diff;
        logic        w_ge;

        assign w_rem2 = {r_dv_rem[k-1], 1'b0};
        assign w_diff = w_rem2 - {1'b0, r_dv_s[k-1]};
        assign w_ge   = (w_rem2 >= {1'b0, r_dv_s[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (w_adv) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem[k]  <= w_ge ? w_diff[SW-1:0] : w_rem2[SW-1:0];
                r_dv_q[k]    <= {r_dv_q[k-1][QB-2:0], w_ge};
                r_dv_s[k]    <= r_dv_s[k-1];
                r_dv_sat[k]  <= r_dv_sat[k-1];
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ---------------- offset times ratio ----------------
    logic [QB-1:0]        w_ratio;
    logic signed [PW-1:0] n_mx_px;
    logic signed [PW-1:0] n_mx_py;
    logic signed [PW-1:0] r_mx_px;
    logic signed [PW-1:0] r_mx_py;
    fcm_pkg::t_side       r_mx_side;
    logic                 r_mx_valid;

    assign w_ratio = r_dv_sat[QB] ? '1 : r_dv_q[QB];
    assign n_mx_px = r_dv_side[QB].hx * $signed({1'b0, w_ratio});
    assign n_mx_py = r_dv_side[QB].hy * $signed({1'b0, w_ratio});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mx_valid <= 1'b0;
        end else if (w_adv) begin
            r_mx_valid <= r_dv_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx_px   <= n_mx_px;
            r_mx_py   <= n_mx_py;
            r_mx_side <= r_dv_side[QB];
        end
    end

    // ---------------- size * 2^F plus product ----------------
    logic signed [NW-1:0] r_nm_x;
    logic signed [NW-1:0] r_nm_y;
    fcm_pkg::t_side       r_nm_side;
    logic                 r_nm_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_valid <= 1'b0;
        end else if (w_adv) begin
            r_nm_valid <= r_mx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nm_x <= $signed({{(NW-MB-F){1'b0}}, r_width, {F{1'b0}}}) + NW'(r_mx_px);
            r_nm_y <= $signed({{(NW-MB-F){1'b0}}, r_height, {F{1'b0}}}) + NW'(r_mx_py);
            r_nm_side <= r_mx_side;
        end
    end

    // ---------------- divide by 2^(F+1), truncating toward zero ----------------
    logic signed [NW-1:0] w_bx;
    logic signed [NW-1:0] w_by;
    logic signed [NW-1:0] w_shx;
    logic signed [NW-1:0] w_shy;
    logic signed [QW-1:0] n_qt_x;
    logic signed [QW-1:0] n_qt_y;
    logic signed [QW-1:0] r_qt_x;
    logic signed [QW-1:0] r_qt_y;
    logic [fcm_pkg::COLOR_W-1:0] r_qt_color;
    logic                 r_qt_valid;

    assign w_bx  = r_nm_x + (r_nm_x[NW-1] ? $signed(BIAS) : $signed(NW'(0)));
    assign w_by  = r_nm_y + (r_nm_y[NW-1] ? $signed(BIAS) : $signed(NW'(0)));
    assign w_shx = w_bx >>> (F + 1);
    assign w_shy = w_by >>> (F + 1);

    // At the exact centre the pixel lands on the floored centre.
    assign n_qt_x = r_nm_side.zero ? $signed({{(QW-MB+1){1'b0}}, r_width[MB-1:1]})
                                   : w_shx[QW-1:0];
    assign n_qt_y = r_nm_side.zero ? $signed({{(QW-MB+1){1'b0}}, r_height[MB-1:1]})
                                   : w_shy[QW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qt_valid <= 1'b0;
        end else if (w_adv) begin
            r_qt_valid <= r_nm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qt_x     <= n_qt_x;
            r_qt_y     <= n_qt_y;
            r_qt_color <= r_nm_side.color;
        end
    end

    // ---------------- saturation, bounds and output register ----------------
    logic signed [31:0] w_x32;
    logic signed [31:0] w_y32;
    fcm_pkg::t_dst      n_out;
    fcm_pkg::t_dst      r_out;

    assign w_x32 = 32'(r_qt_x);
    assign w_y32 = 32'(r_qt_y);

    always_comb begin
        priority if (w_x32 > fcm_pkg::DST_MAX) begin
            n_out.dst_x = fcm_pkg::DST_W'(fcm_pkg::DST_MAX);
        end else if (w_x32 < fcm_pkg::DST_MIN) begin
            n_out.dst_x = fcm_pkg::DST_W'(fcm_pkg::DST_MIN);
        end else begin
            n_out.dst_x = w_x32[fcm_pkg::DST_W-1:0];
        end
        priority if (w_y32 > fcm_pkg::DST_MAX) begin
            n_out.dst_y = fcm_pkg::DST_W'(fcm_pkg::DST_MAX);
        end else if (w_y32 < fcm_pkg::DST_MIN) begin
            n_out.dst_y = fcm_pkg::DST_W'(fcm_pkg::DST_MIN);
        end else begin
            n_out.dst_y = w_y32[fcm_pkg::DST_W-1:0];
        end
        n_out.in_bounds = !r_qt_x[QW-1] && !r_qt_y[QW-1]
                          && ($unsigned(r_qt_x) < {{(QW-MB){1'b0}}, r_width})
                          && ($unsigned(r_qt_y) < {{(QW-MB){1'b0}}, r_height});
        n_out.dst_color = r_qt_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_qt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_dst_valid = r_out_valid;
    assign o_dst       = r_out;

    // ---------------- checks ----------------
    `FCM_ASSERT_IMPLIES(a_inb_nonneg, o_dst_valid && o_dst.in_bounds, !o_dst.dst_x[fcm_pkg::DST_W-1] && !o_dst.dst_y[fcm_pkg::DST_W-1])
    `FCM_ASSERT_IMPLIES(a_div_seed_below, r_dv_valid[0] && !r_dv_sat[0], r_dv_rem[0] < r_dv_s[0])
    `FCM_ASSERT_NEXT(a_freeze_on_stall, !w_adv, $stable(r_mx_px) && $stable(r_dv_q[QB]) && $stable(r_qt_x))

endmodule

// ===== src/fcm_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word and a valid bit alongside; uses no package items.
module fcm_isqrt_pipe #(
    parameter int IN_W   = 46,
    parameter int SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int RT = IN_W / 2;

    logic              r_valid [0:RT-1];
    logic [RT:0]       r_rem   [0:RT-1];
    logic [RT-1:0]     r_root  [0:RT-1];
    logic [IN_W-1:0]   r_rad   [0:RT-1];
    logic [SIDE_W-1:0] r_side  [0:RT-1];

    for (genvar k = 0; k < RT; k++) begin : g_stage
        logic              w_valid;
        logic [RT:0]       w_rem;
        logic [RT-1:0]     w_root;
        logic [IN_W-1:0]   w_rad;
        logic [SIDE_W-1:0] w_side;
        logic [RT+2:0]     w_rem2;
        logic [RT+2:0]     w_trial;
        logic [RT+2:0]     w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_rem   = '0;
            assign w_root  = '0;
            assign w_rad   = i_rad;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_root  = r_root[k-1];
            assign w_rad   = r_rad[k-1];
            assign w_side  = r_side[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign w_rem2  = {w_rem, w_rad[IN_W-1 -: 2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_diff  = w_rem2 - w_trial;
        assign w_ge    = (w_rem2 >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[RT:0] : w_rem2[RT:0];
                r_root[k] <= {w_root[RT-2:0], w_ge};
                r_rad[k]  <= {w_rad[IN_W-3:0], 2'b00};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[RT-1];
    assign o_root  = r_root[RT-1];
    assign o_side  = r_side[RT-1];

endmodule
